[src/rfdf_pkg.sv]
// rfdf_pkg: shared symbols, mode and sequencer codes, and the frame command
// passed from the deframer front end to the output sequencer
// no dependencies
package rfdf_pkg;

    localparam logic [7:0] SYM_START = 8'd18;
    localparam logic [7:0] SYM_STOP  = 8'd19;
    localparam logic [7:0] SYM_ESC   = 8'd125;

    localparam logic [1:0] CH_TX      = 2'd0;
    localparam logic [1:0] CH_DELIVER = 2'd1;
    localparam logic [1:0] CH_DROP    = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_READ = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_ERR  = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_START,
        B_FETCH,
        B_STUFF,
        B_BYTE,
        B_STOP,
        B_DFETCH,
        B_DELIV,
        B_DROP
    } bstate_t;

    // one finished frame, handed to the back end
    typedef struct packed {
        logic       fwd;      // ttl nonzero and frame not empty
        logic       deliver;  // fifo space exceeds frame length
        logic [7:0] len;
    } cmd_t;

endpackage

[src/ring_frame_deframe_forward.sv]
// ring_frame_deframe_forward: top level, front end deframer joined to the
// output sequencer through a one-entry frame command; uses rfdf_front, rfdf_back
//
//  port group  | dir | tdata bits (low first)         | tuser    | tlast
//  s_axis_*    | in  | rx_byte[7:0], fifo_space[15:8] | -        | -
//  m_axis_*    | out | data[7:0]                      | channel  | last
//
// one received byte is taken per cycle while the front end is free; the cycle
// after a stop transfer takes none while the frame command is handed over
// the back end takes the command in that cycle and then emits, as the command
// selects: a start, each forwarded byte (after an escape when special), a stop,
// then either each delivered byte or a drop notice; the registered frame store
// read port puts a fetch state before each byte; bytes after the start of a new
// frame stall until the back end has issued the last result of the previous frame
// reset is synchronous, active low; the output holds under m_axis_tready low
module ring_frame_deframe_forward #(
    parameter int FRAME_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rx_byte, fifo_space
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // data
    output logic [1:0]  m_axis_tuser,   // channel
    output logic        m_axis_tlast
);
    import rfdf_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          cmd_valid;
    logic          cmd_ready;
    cmd_t          cmd;
    logic          back_busy;

    rfdf_front #(
        .FRAME_DEPTH(FRAME_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .rx_byte    (s_axis_tdata[7:0]),
        .fifo_space (s_axis_tdata[15:8]),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .back_busy  (back_busy)
    );

    rfdf_back #(
        .FRAME_DEPTH(FRAME_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .back_busy   (back_busy),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_channel (m_axis_tuser),
        .out_data    (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

endmodule

[src/rfdf_front.sv]
// rfdf_front: deframer state machine, writes unstuffed bytes to the frame store
// and posts a one-entry frame command on stop; uses rfdf_pkg
module rfdf_front #(
    parameter int FRAME_DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      rx_byte,
    input  logic [7:0]                      fifo_space,
    output logic                            wr_en,
    output logic [$clog2(FRAME_DEPTH)-1:0]  wr_addr,
    output logic [7:0]                      wr_data,
    output logic                            cmd_valid,
    input  logic                            cmd_ready,
    output rfdf_pkg::cmd_t                  cmd,
    input  logic                            back_busy
);
    import rfdf_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int LW = $clog2(FRAME_DEPTH + 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(FRAME_DEPTH);

    mode_t         mode_reg, mode_next;
    logic [LW-1:0] len_reg, len_next;
    logic [7:0]    ttl_reg, ttl_next;
    logic          cmd_valid_reg, cmd_valid_next;
    cmd_t          cmd_reg, cmd_next;
    logic          accept;
    logic          store;

    // bytes inside a frame wait until the back end is idle and done reading the store
    assign in_ready = !cmd_valid_reg &&
                      (!back_busy || mode_reg == MODE_IDLE || mode_reg == MODE_ERR);
    assign accept   = in_valid && in_ready;

    always_comb begin
        mode_next      = mode_reg;
        len_next       = len_reg;
        ttl_next       = ttl_reg;
        cmd_valid_next = cmd_valid_reg;
        cmd_next       = cmd_reg;
        store          = 1'b0;
        if (cmd_valid_reg && cmd_ready) begin
            cmd_valid_next = 1'b0;
        end
        if (accept) begin
            case (mode_reg)
                MODE_IDLE: begin
                    if (rx_byte == SYM_START) begin
                        mode_next = MODE_READ;
                        len_next  = '0;
                    end
                end
                MODE_READ: begin
                    if (len_reg >= DEPTH_L) begin
                        mode_next = MODE_ERR;
                    end else if (rx_byte == SYM_STOP) begin
                        mode_next        = MODE_IDLE;
                        cmd_valid_next   = 1'b1;
                        cmd_next.fwd     = (len_reg != '0) && (ttl_reg != 8'd0);
                        cmd_next.deliver = {1'b0, fifo_space} > 9'(len_reg);
                        cmd_next.len     = 8'(len_reg);
                    end else if (rx_byte == SYM_ESC) begin
                        mode_next = MODE_ESC;
                    end else begin
                        store = 1'b1;
                    end
                end
                MODE_ESC: begin
                    if (len_reg >= DEPTH_L) begin
                        mode_next = MODE_ERR;
                    end else begin
                        store     = 1'b1;
                        mode_next = MODE_READ;
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                    len_next  = '0;
                end
            endcase
        end
        if (store) begin
            len_next = len_reg + LW'(1);
            if (len_reg == '0) begin
                ttl_next = rx_byte;
            end
        end
    end

    assign wr_en     = store;
    assign wr_addr   = AW'(len_reg);
    assign wr_data   = rx_byte;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            len_reg       <= '0;
            cmd_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            len_reg       <= len_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ttl_reg <= ttl_next;
        cmd_reg <= cmd_next;
    end

endmodule

[src/rfdf_back.sv]
// rfdf_back: frame store and output sequencer that re-sends, delivers or drops
// a finished frame through a registered output stage; uses rfdf_pkg
module rfdf_back #(
    parameter int FRAME_DEPTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [$clog2(FRAME_DEPTH)-1:0]  wr_addr,
    input  logic [7:0]                      wr_data,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  rfdf_pkg::cmd_t                  cmd,
    output logic                            back_busy,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      out_channel,
    output logic [7:0]                      out_data,
    output logic                            out_last
);
    import rfdf_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int LW = $clog2(FRAME_DEPTH + 1);

    logic [7:0]    mem [FRAME_DEPTH];
    logic [7:0]    rd_data_reg;

    bstate_t       state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [LW-1:0] len_reg, len_next;
    logic          deliver_reg, deliver_next;

    logic          valid_reg;
    logic [1:0]    chan_reg;
    logic [7:0]    data_reg;
    logic          last_reg;

    logic          out_free;
    logic          emit;
    logic [1:0]    emit_ch;
    logic [7:0]    emit_data;
    logic          emit_last;
    logic [7:0]    val;
    logic          special;
    logic [LW-1:0] idx_inc;
    logic          more;
    logic [LW-1:0] cmd_len;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg];
    end

    assign out_free  = !valid_reg || out_ready;
    assign cmd_ready = (state_reg == B_IDLE);
    assign back_busy = (state_reg != B_IDLE);

    // ttl goes out decremented
    assign val     = (idx_reg == '0) ? rd_data_reg - 8'd1 : rd_data_reg;
    assign special = (val == SYM_START) || (val == SYM_STOP) || (val == SYM_ESC);
    assign idx_inc = LW'(idx_reg) + LW'(1);
    assign more    = idx_inc < len_reg;
    assign cmd_len = LW'(cmd.len);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        deliver_next = deliver_reg;
        emit         = 1'b0;
        emit_ch      = CH_TX;
        emit_data    = 8'd0;
        emit_last    = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (cmd_valid) begin
                    len_next     = cmd_len;
                    deliver_next = cmd.deliver;
                    if (cmd.fwd) begin
                        state_next = B_START;
                    end else if (!cmd.deliver) begin
                        state_next = B_DROP;
                    end else if (cmd_len > LW'(1)) begin
                        idx_next   = AW'(1);
                        state_next = B_DFETCH;
                    end
                end
            end
            B_START: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_data  = SYM_START;
                    idx_next   = '0;
                    state_next = B_FETCH;
                end
            end
            B_FETCH: begin
                state_next = B_STUFF;
            end
            B_STUFF, B_BYTE: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (state_reg == B_STUFF && special) begin
                        emit_data  = SYM_ESC;
                        state_next = B_BYTE;
                    end else begin
                        emit_data = val;
                        if (more) begin
                            idx_next   = AW'(idx_inc);
                            state_next = B_FETCH;
                        end else begin
                            state_next = B_STOP;
                        end
                    end
                end
            end
            B_STOP: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_data = SYM_STOP;
                    emit_last = deliver_reg && (len_reg < LW'(2));
                    if (!deliver_reg) begin
                        state_next = B_DROP;
                    end else if (len_reg > LW'(1)) begin
                        idx_next   = AW'(1);
                        state_next = B_DFETCH;
                    end else begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_DFETCH: begin
                state_next = B_DELIV;
            end
            B_DELIV: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_ch   = CH_DELIVER;
                    emit_data = rd_data_reg;
                    emit_last = !more;
                    if (more) begin
                        idx_next   = AW'(idx_inc);
                        state_next = B_DFETCH;
                    end else begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_DROP: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_ch    = CH_DROP;
                    emit_data  = 8'(len_reg);
                    emit_last  = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        len_reg     <= len_next;
        deliver_reg <= deliver_next;
        if (emit) begin
            chan_reg <= emit_ch;
            data_reg <= emit_data;
            last_reg <= emit_last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_channel = chan_reg;
    assign out_data    = data_reg;
    assign out_last    = last_reg;

endmodule
